### hw/rtl/tbd_pkg.sv
package tbd_pkg;

   // CORDIC datapath: positions are scaled up to 60 bits, so 64 bits hold the growth
   localparam int VEC_W = 64;
   // angle accumulator, 2^32 per full turn
   localparam int ANG_W = 32;

   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ANG_W-1:0]        z;
      logic                    zero;
   } vec_type;

   // atan(2^-i) in units of 2^-32 turn, rounded
   localparam logic [ANG_W-1:0] ATAN_TAB [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

### hw/rtl/tbd_entry.sv
module tbd_entry
   import tbd_pkg::*;
#(
   parameter int POS_BITS   = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic                          req_type,
   input  logic signed [POS_BITS-1:0]    robot_x,
   input  logic signed [POS_BITS-1:0]    robot_y,
   input  logic signed [ANGLE_BITS-1:0]  robot_heading,
   input  logic signed [POS_BITS-1:0]    goal_x,
   input  logic signed [POS_BITS-1:0]    goal_y,
   input  logic signed [ANGLE_BITS-1:0]  goal_heading,
   output logic                          out_valid,
   output vec_type                       out_vec,
   output logic [2*POS_BITS+1:0]         out_sum,
   output logic [ANGLE_BITS-1:0]         out_ref
);

   localparam int DIFF_W      = POS_BITS + 1;
   localparam int SUM_W       = 2 * POS_BITS + 2;
   localparam int SCALE_SHIFT = 60 - POS_BITS;

   // stage a: differences
   logic                     a_valid_ff, a_valid_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in;
   logic signed [DIFF_W-1:0] dy_ff, dy_in;
   logic [ANGLE_BITS-1:0]    a_ref_ff, a_ref_in;

   // stage b: prescale, squares
   logic                     b_valid_ff;
   vec_type                  b_vec_ff, b_vec_in;
   logic [SUM_W-1:0]         sqx_ff, sqx_in;
   logic [SUM_W-1:0]         sqy_ff, sqy_in;
   logic [ANGLE_BITS-1:0]    b_ref_ff;
   logic signed [VEC_W-1:0]  xw, yw;
   logic [DIFF_W-1:0]        ax, ay;

   // stage c: sum of squares
   logic                     c_valid_ff;
   vec_type                  c_vec_ff;
   logic [SUM_W-1:0]         c_sum_ff, c_sum_in;
   logic [ANGLE_BITS-1:0]    c_ref_ff;

   // heading mode: zero vector gives target angle 0, so ref = head - goal gives goal - head
   always_comb begin
      a_valid_in = in_valid;
      if (req_type) begin
         dx_in    = '0;
         dy_in    = '0;
         a_ref_in = robot_heading - goal_heading;
      end else begin
         dx_in    = DIFF_W'(goal_x) - DIFF_W'(robot_x);
         dy_in    = DIFF_W'(goal_y) - DIFF_W'(robot_y);
         a_ref_in = robot_heading;
      end
   end

   always_comb begin
      xw = VEC_W'(dx_ff) <<< SCALE_SHIFT;
      yw = VEC_W'(dy_ff) <<< SCALE_SHIFT;
      b_vec_in.zero = (dx_ff == '0) && (dy_ff == '0);
      if (xw[VEC_W-1]) begin
         b_vec_in.x = -xw;
         b_vec_in.y = -yw;
         b_vec_in.z = HALF_TURN;
      end else begin
         b_vec_in.x = xw;
         b_vec_in.y = yw;
         b_vec_in.z = '0;
      end
      ax = dx_ff[DIFF_W-1] ? $unsigned(-dx_ff) : $unsigned(dx_ff);
      ay = dy_ff[DIFF_W-1] ? $unsigned(-dy_ff) : $unsigned(dy_ff);
      sqx_in = SUM_W'(ax * ax);
      sqy_in = SUM_W'(ay * ay);
   end

   // cannot overflow: |dx|, |dy| stay below 2^POS_BITS
   assign c_sum_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         a_ref_ff <= a_ref_in;
         b_vec_ff <= b_vec_in;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         b_ref_ff <= a_ref_ff;
         c_vec_ff <= b_vec_ff;
         c_sum_ff <= c_sum_in;
         c_ref_ff <= b_ref_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_vec   = c_vec_ff;
   assign out_sum   = c_sum_ff;
   assign out_ref   = c_ref_ff;

endmodule

### hw/rtl/tbd_cell.sv
module tbd_cell
   import tbd_pkg::*;
#(
   parameter int POS_BITS      = 24,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 18,
   parameter int INDEX         = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  vec_type                   in_vec,
   input  logic [2*POS_BITS+1:0]     in_sum,
   input  logic [POS_BITS:0]         in_root,
   input  logic [POS_BITS+1:0]       in_rem,
   input  logic [ANGLE_BITS-1:0]     in_ref,
   output logic                      out_valid,
   output vec_type                   out_vec,
   output logic [2*POS_BITS+1:0]     out_sum,
   output logic [POS_BITS:0]         out_root,
   output logic [POS_BITS+1:0]       out_rem,
   output logic [ANGLE_BITS-1:0]     out_ref
);

   localparam int ROOT_BITS = POS_BITS + 1;
   localparam int SUM_W     = 2 * ROOT_BITS;
   localparam int REM_KEEP  = ROOT_BITS + 1;
   localparam int REM_W     = ROOT_BITS + 3;

   logic                  valid_ff;
   vec_type               vec_ff, vec_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [REM_KEEP-1:0]   rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] ref_ff;

   generate
      if (INDEX < CORDIC_STAGES) begin : g_rot
         localparam logic [ANG_W-1:0] STEP_ANGLE = ATAN_TAB[INDEX % 32];
         always_comb begin
            vec_in.zero = in_vec.zero;
            if (!in_vec.y[VEC_W-1]) begin
               vec_in.x = in_vec.x + (in_vec.y >>> INDEX);
               vec_in.y = in_vec.y - (in_vec.x >>> INDEX);
               vec_in.z = in_vec.z + STEP_ANGLE;
            end else begin
               vec_in.x = in_vec.x - (in_vec.y >>> INDEX);
               vec_in.y = in_vec.y + (in_vec.x >>> INDEX);
               vec_in.z = in_vec.z - STEP_ANGLE;
            end
         end
      end else begin : g_rot_idle
         assign vec_in = in_vec;
      end

      // one root bit per cell in the first ROOT_BITS cells, restoring digit-by-digit method
      if (INDEX < ROOT_BITS) begin : g_root
         logic [REM_W-1:0] rem_t;
         logic [REM_W-1:0] trial;
         always_comb begin
            rem_t  = {in_rem, in_sum[SUM_W-1 -: 2]};
            trial  = {1'b0, in_root, 2'b01};
            sum_in = {in_sum[SUM_W-3:0], 2'b00};
            if (rem_t >= trial) begin
               rem_in  = REM_KEEP'(rem_t - trial);
               root_in = {in_root[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = REM_KEEP'(rem_t);
               root_in = {in_root[ROOT_BITS-2:0], 1'b0};
            end
         end
      end else begin : g_root_idle
         assign sum_in  = in_sum;
         assign root_in = in_root;
         assign rem_in  = in_rem;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in;
         sum_ff  <= sum_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
         ref_ff  <= in_ref;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_sum   = sum_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;
   assign out_ref   = ref_ff;

endmodule

### hw/rtl/tbd_finish.sv
module tbd_finish
   import tbd_pkg::*;
#(
   parameter int POS_BITS   = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  vec_type                in_vec,
   input  logic [POS_BITS:0]      in_root,
   input  logic [POS_BITS+1:0]    in_rem,
   input  logic [ANGLE_BITS-1:0]  in_ref,
   output logic                   out_valid,
   output logic [POS_BITS:0]      distance,
   output logic [ANGLE_BITS:0]    bearing_error,
   output logic                   turn_clockwise
);

   localparam int ROOT_BITS = POS_BITS + 1;
   localparam logic [ANG_W-1:0] ROUND_BIT = ANG_W'(1) << (ANG_W - 1 - ANGLE_BITS);
   localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   logic                  valid_ff;
   logic [ROOT_BITS-1:0]  dist_ff, dist_in;
   logic [ANGLE_BITS:0]   err_ff, err_in;
   logic [ANG_W-1:0]      z_rnd;
   logic [ANGLE_BITS-1:0] target;
   logic [ANGLE_BITS-1:0] diff;

   always_comb begin
      z_rnd  = in_vec.z + ROUND_BIT;
      target = in_vec.zero ? '0 : z_rnd[ANG_W-1 -: ANGLE_BITS];
      diff   = target - in_ref;
      // above half a turn wraps negative; exactly half stays positive
      err_in = {diff > HALF, diff};
      // remainder beyond the floor root means the exact root lies past the midpoint
      dist_in = in_root + ROOT_BITS'(in_rem > {1'b0, in_root});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         err_ff  <= err_in;
      end
   end

   assign out_valid      = valid_ff;
   assign distance       = dist_ff;
   assign bearing_error  = err_ff;
   assign turn_clockwise = err_ff[ANGLE_BITS];

endmodule

### hw/rtl/target_bearing_distance.sv
// channel | dir | tdata (low bit up)                                   | tuser
// req_    | in  | robot_x, robot_y, robot_heading, goal_x, goal_y,      | req_type
//         |     | goal_heading                                         |
// rsp_    | out | distance, bearing_error, turn_clockwise, zero pad     | -
//
// One item per cycle sustained while the output is not stalled. In the chain of cells
// the first CORDIC_STAGES each do one CORDIC rotation and the first POS_BITS+1 each
// one square-root bit. Synchronous reset clears all valid flags.
// A stalled output keeps one more result in a skid register; req_tready drops only
// once that register is full, and the whole chain then holds.
module target_bearing_distance
   import tbd_pkg::*;
#(
   parameter int POS_BITS      = 24,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 18,
   localparam int REQ_W = ((4 * POS_BITS + 2 * ANGLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((POS_BITS + ANGLE_BITS + 3 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // robot_x, robot_y, robot_heading, goal_x, goal_y, goal_heading
   input  logic [REQ_W-1:0] req_tdata,
   // req_type
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // distance, bearing_error, turn_clockwise, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int ROOT_BITS = POS_BITS + 1;
   localparam int SUM_W     = 2 * ROOT_BITS;
   localparam int CELLS     = (CORDIC_STAGES > ROOT_BITS) ? CORDIC_STAGES : ROOT_BITS;
   localparam int OUT_W     = POS_BITS + ANGLE_BITS + 3;

   localparam int RX_LSB = 0;
   localparam int RY_LSB = POS_BITS;
   localparam int RH_LSB = 2 * POS_BITS;
   localparam int GX_LSB = 2 * POS_BITS + ANGLE_BITS;
   localparam int GY_LSB = 3 * POS_BITS + ANGLE_BITS;
   localparam int GH_LSB = 4 * POS_BITS + ANGLE_BITS;

   logic                  adv;
   logic                  ch_valid [CELLS+1];
   vec_type               ch_vec   [CELLS+1];
   logic [SUM_W-1:0]      ch_sum   [CELLS+1];
   logic [ROOT_BITS-1:0]  ch_root  [CELLS+1];
   logic [ROOT_BITS:0]    ch_rem   [CELLS+1];
   logic [ANGLE_BITS-1:0] ch_ref   [CELLS+1];

   logic                  fin_valid;
   logic [ROOT_BITS-1:0]  fin_dist;
   logic [ANGLE_BITS:0]   fin_err;
   logic                  fin_cw;
   logic [OUT_W-1:0]      fin_word;

   logic                  take;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]      rsp_word_ff, rsp_word_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [OUT_W-1:0]      skid_word_ff, skid_word_in;

   // the chain moves whenever the skid register is free
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   tbd_entry #(
      .POS_BITS   (POS_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_entry (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .in_valid      (req_tvalid),
      .req_type      (req_tuser),
      .robot_x       (req_tdata[RX_LSB +: POS_BITS]),
      .robot_y       (req_tdata[RY_LSB +: POS_BITS]),
      .robot_heading (req_tdata[RH_LSB +: ANGLE_BITS]),
      .goal_x        (req_tdata[GX_LSB +: POS_BITS]),
      .goal_y        (req_tdata[GY_LSB +: POS_BITS]),
      .goal_heading  (req_tdata[GH_LSB +: ANGLE_BITS]),
      .out_valid     (ch_valid[0]),
      .out_vec       (ch_vec[0]),
      .out_sum       (ch_sum[0]),
      .out_ref       (ch_ref[0])
   );

   assign ch_root[0] = '0;
   assign ch_rem[0]  = '0;

   generate
      for (genvar i = 0; i < CELLS; i++) begin : g_cell
         tbd_cell #(
            .POS_BITS      (POS_BITS),
            .ANGLE_BITS    (ANGLE_BITS),
            .CORDIC_STAGES (CORDIC_STAGES),
            .INDEX         (i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (adv),
            .in_valid  (ch_valid[i]),
            .in_vec    (ch_vec[i]),
            .in_sum    (ch_sum[i]),
            .in_root   (ch_root[i]),
            .in_rem    (ch_rem[i]),
            .in_ref    (ch_ref[i]),
            .out_valid (ch_valid[i+1]),
            .out_vec   (ch_vec[i+1]),
            .out_sum   (ch_sum[i+1]),
            .out_root  (ch_root[i+1]),
            .out_rem   (ch_rem[i+1]),
            .out_ref   (ch_ref[i+1])
         );
      end
   endgenerate

   tbd_finish #(
      .POS_BITS   (POS_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_finish (
      .clock          (clock),
      .reset          (reset),
      .en             (adv),
      .in_valid       (ch_valid[CELLS]),
      .in_vec         (ch_vec[CELLS]),
      .in_root        (ch_root[CELLS]),
      .in_rem         (ch_rem[CELLS]),
      .in_ref         (ch_ref[CELLS]),
      .out_valid      (fin_valid),
      .distance       (fin_dist),
      .bearing_error  (fin_err),
      .turn_clockwise (fin_cw)
   );

   assign fin_word = {fin_cw, fin_err, fin_dist};

   always_comb begin
      take          = rsp_tvalid_ff && rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (fin_valid) begin
         if (!rsp_tvalid_ff || take) begin
            rsp_tvalid_in = 1'b1;
            rsp_word_in   = fin_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = fin_word;
         end
      end else if (take) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(rsp_word_ff);

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(fin_valid))
      else $error("chain moved while the skid register was full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tready && skid_valid_ff |=> rsp_tvalid_ff && !skid_valid_ff)
      else $error("skid result not moved to the output after a transfer");

endmodule
